FILE: hdl/watering_cycle_sequencer_assert.svh
// assertion macros for the watering cycle sequencer
`ifndef WATERING_CYCLE_SEQUENCER_ASSERT_SVH
`define WATERING_CYCLE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watering cycle sequencer check failed");

// next-cycle implication, checked out of reset
`define WCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watering cycle sequencer check failed");

`endif

FILE: hdl/wcs_pkg.sv
// shared types and codes of the watering cycle sequencer
package wcs_pkg;

  localparam int unsigned HUM_W  = 10;
  localparam int unsigned SEC_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PASS_W = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] MS_PER_MINUTE = 32'd60000;

  // command codes
  localparam logic [1:0] CMD_RUN     = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_RESET   = 2'd2;

  // mode codes as seen on the result
  localparam logic [3:0] MODE_IDLE       = 4'd0;
  localparam logic [3:0] MODE_WAIT_SOIL  = 4'd1;
  localparam logic [3:0] MODE_SENSE_SOIL = 4'd2;
  localparam logic [3:0] MODE_WAIT_TANK  = 4'd3;
  localparam logic [3:0] MODE_SENSE_TANK = 4'd4;
  localparam logic [3:0] MODE_WAIT_PUMP  = 4'd5;
  localparam logic [3:0] MODE_PUMP       = 4'd6;
  localparam logic [3:0] MODE_SOAK       = 4'd7;
  localparam logic [3:0] MODE_TANK_EMPTY = 4'd8;

  // sensor actions
  localparam logic [1:0] SENS_NONE         = 2'd0;
  localparam logic [1:0] SENS_ENABLE       = 2'd1;
  localparam logic [1:0] SENS_POLL         = 2'd2;
  localparam logic [1:0] SENS_POLL_DISABLE = 2'd3;

  // pump and valve actions
  localparam logic [1:0] PUMP_NONE  = 2'd0;
  localparam logic [1:0] PUMP_START = 2'd1;
  localparam logic [1:0] PUMP_STOP  = 2'd2;

  // events
  localparam logic [2:0] EVT_NONE         = 3'd0;
  localparam logic [2:0] EVT_SOIL_NOT_DRY = 3'd1;
  localparam logic [2:0] EVT_TANK_EMPTY   = 3'd2;
  localparam logic [2:0] EVT_MAX_PASSES   = 3'd3;
  localparam logic [2:0] EVT_TANK_RECHECK = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DRY_THRESHOLD       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_THRESHOLD       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RESERVOIR_THRESHOLD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PUMP_TIME_SECONDS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SOAK_MINUTES        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PASSES          = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RECHECK_INTERVAL_MS = 3'd6;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              soil_sensor_idle;
    logic              soil_sensor_ready;
    logic [HUM_W-1:0]  soil_reading;
    logic              tank_sensor_idle;
    logic              tank_sensor_ready;
    logic [HUM_W-1:0]  tank_reading;
    logic              pump_running;
    logic [SEC_W-1:0]  pump_on_seconds;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [1:0]        soil_sensor_action;
    logic [1:0]        tank_sensor_action;
    logic [1:0]        pump_valve_action;
    logic [HUM_W-1:0]  last_humidity;
    logic [PASS_W-1:0] pass_count;
    logic [2:0]        event_res;
  } out_t;

  // live settings; the soak limit is kept as a millisecond bound
  typedef struct packed {
    logic [HUM_W-1:0]  dry_threshold;
    logic [HUM_W-1:0]  wet_threshold;
    logic [HUM_W-1:0]  reservoir_threshold;
    logic [SEC_W-1:0]  pump_time_seconds;
    logic [TIME_W-1:0] soak_limit_ms;
    logic [PASS_W-1:0] max_passes;
    logic [TIME_W-1:0] recheck_interval_ms;
  } cfg_t;

endpackage

FILE: hdl/wcs_core.sv
// sequencer state machine with its result register
module wcs_core import wcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  req,
  input  cfg_t cfg,
  output out_t res_r
);

  typedef enum logic [3:0] {
    S_IDLE       = MODE_IDLE,
    S_WAIT_SOIL  = MODE_WAIT_SOIL,
    S_SENSE_SOIL = MODE_SENSE_SOIL,
    S_WAIT_TANK  = MODE_WAIT_TANK,
    S_SENSE_TANK = MODE_SENSE_TANK,
    S_WAIT_PUMP  = MODE_WAIT_PUMP,
    S_PUMP       = MODE_PUMP,
    S_SOAK       = MODE_SOAK,
    S_TANK_EMPTY = MODE_TANK_EMPTY
  } state_t;

  state_t            state_r, state_nxt;
  logic [PASS_W-1:0] passes_r, passes_nxt;
  logic [HUM_W-1:0]  hum_r, hum_nxt;
  logic [TIME_W-1:0] soak_start_r, soak_start_nxt;
  logic [TIME_W-1:0] empty_start_r, empty_start_nxt;
  logic [1:0]        soil_act, tank_act, pump_act;
  logic [2:0]        evt;
  logic [TIME_W-1:0] soak_elapsed, empty_elapsed;
  logic [HUM_W-1:0]  soil_limit;
  logic [PASS_W-1:0] passes_inc;

  // wrap-around elapsed times
  assign soak_elapsed  = req.now_ms - soak_start_r;
  assign empty_elapsed = req.now_ms - empty_start_r;
  assign soil_limit    = (passes_r == '0) ? cfg.dry_threshold : cfg.wet_threshold;
  assign passes_inc    = passes_r + PASS_W'(1);

  always_comb begin
    state_nxt       = state_r;
    passes_nxt      = passes_r;
    hum_nxt         = hum_r;
    soak_start_nxt  = soak_start_r;
    empty_start_nxt = empty_start_r;
    soil_act        = SENS_NONE;
    tank_act        = SENS_NONE;
    pump_act        = PUMP_NONE;
    evt             = EVT_NONE;
    case (req.cmd)
      CMD_TRIGGER: begin
        if (state_r == S_IDLE) begin
          state_nxt  = S_WAIT_SOIL;
          passes_nxt = '0;
        end
      end
      CMD_RESET: begin
        if (state_r == S_SENSE_SOIL) soil_act = SENS_POLL_DISABLE;
        if (state_r == S_SENSE_TANK) tank_act = SENS_POLL_DISABLE;
        if (state_r == S_PUMP) pump_act = PUMP_STOP;
        state_nxt = S_IDLE;
      end
      CMD_RUN: begin
        unique case (state_r)
          S_IDLE: begin
          end
          S_WAIT_SOIL: begin
            if (req.soil_sensor_idle) begin
              soil_act  = SENS_ENABLE;
              state_nxt = S_SENSE_SOIL;
            end
          end
          S_SENSE_SOIL: begin
            soil_act = SENS_POLL;
            if (req.soil_sensor_ready) begin
              soil_act = SENS_POLL_DISABLE;
              hum_nxt  = req.soil_reading;
              if (req.soil_reading > soil_limit) begin
                state_nxt = S_IDLE;
                evt       = EVT_SOIL_NOT_DRY;
              end else if (cfg.reservoir_threshold == '0) begin
                state_nxt = S_WAIT_PUMP;
              end else begin
                state_nxt = S_WAIT_TANK;
              end
            end
          end
          S_WAIT_TANK: begin
            if (req.tank_sensor_idle) begin
              tank_act  = SENS_ENABLE;
              state_nxt = S_SENSE_TANK;
            end
          end
          S_SENSE_TANK: begin
            tank_act = SENS_POLL;
            if (req.tank_sensor_ready) begin
              tank_act = SENS_POLL_DISABLE;
              if (req.tank_reading < cfg.reservoir_threshold) begin
                empty_start_nxt = req.now_ms;
                state_nxt       = S_TANK_EMPTY;
                evt             = EVT_TANK_EMPTY;
              end else begin
                state_nxt = S_WAIT_PUMP;
              end
            end
          end
          S_WAIT_PUMP: begin
            if (!req.pump_running) begin
              pump_act  = PUMP_START;
              state_nxt = S_PUMP;
            end
          end
          S_PUMP: begin
            if (req.pump_on_seconds >= cfg.pump_time_seconds) begin
              pump_act       = PUMP_STOP;
              soak_start_nxt = req.now_ms;
              state_nxt      = S_SOAK;
            end
          end
          S_SOAK: begin
            // whole minutes exceed the soak time
            if (soak_elapsed >= cfg.soak_limit_ms) begin
              passes_nxt = passes_inc;
              if (passes_inc >= cfg.max_passes) begin
                state_nxt = S_IDLE;
                evt       = EVT_MAX_PASSES;
              end else begin
                state_nxt = S_WAIT_SOIL;
              end
            end
          end
          S_TANK_EMPTY: begin
            if (empty_elapsed > cfg.recheck_interval_ms) begin
              state_nxt = S_WAIT_TANK;
              evt       = EVT_TANK_RECHECK;
            end
          end
          default: begin
            state_nxt = state_r;
          end
        endcase
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      passes_r      <= '0;
      hum_r         <= '0;
      soak_start_r  <= '0;
      empty_start_r <= '0;
    end else if (fire) begin
      state_r                  <= state_nxt;
      passes_r                 <= passes_nxt;
      hum_r                    <= hum_nxt;
      soak_start_r             <= soak_start_nxt;
      empty_start_r            <= empty_start_nxt;
      res_r.mode               <= 4'(state_nxt);
      res_r.soil_sensor_action <= soil_act;
      res_r.tank_sensor_action <= tank_act;
      res_r.pump_valve_action  <= pump_act;
      res_r.last_humidity      <= hum_nxt;
      res_r.pass_count         <= passes_nxt;
      res_r.event_res          <= evt;
    end
  end

endmodule

FILE: hdl/watering_cycle_sequencer.sv
// top level of the watering cycle sequencer
// One request per cycle is taken while in_ready is high and gives exactly one
// result once the output is free: the request is held in an input register,
// the state machine in wcs_core works on it and loads the result register
// together with its state at the next edge. A waiting result does
// not block the next request, since the input register keeps filling while
// the output is free; in_ready drops only when both registers hold data and
// out_ready is low. Settings are written through the cfg port (always ready)
// and act on the next request that reaches the state machine. The soak time
// is kept as a millisecond bound (minutes plus one, times 60000) worked out
// at write time, so a step needs only a subtract and a compare.
module watering_cycle_sequencer import wcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  // settings write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "watering_cycle_sequencer_assert.svh"

  // soak bound for zero minutes after reset
  localparam logic [TIME_W-1:0] SOAK_LIMIT_RESET = MS_PER_MINUTE;
  localparam logic [TIME_W-1:0] RECHECK_RESET    = 32'd3600000;

  logic        s1_valid_r;
  in_t         s1_req_r;
  logic        out_valid_r;
  logic        s1_adv;
  logic        fire;
  cfg_t        cfg_r;
  logic [32:0] soak_limit_nxt;

  // the input register moves on when the result register is free or drains
  assign s1_adv    = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && s1_adv;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // (minutes + 1) * 60000 stays below 2^32 for every 16-bit minute count
  assign soak_limit_nxt = 33'({1'b0, cfg_data[SEC_W-1:0]} + 17'd1) * 33'(MS_PER_MINUTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_req_r <= in_data;
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_threshold       <= '0;
      cfg_r.wet_threshold       <= '0;
      cfg_r.reservoir_threshold <= '0;
      cfg_r.pump_time_seconds   <= '0;
      cfg_r.soak_limit_ms       <= SOAK_LIMIT_RESET;
      cfg_r.max_passes          <= PASS_W'(1);
      cfg_r.recheck_interval_ms <= RECHECK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DRY_THRESHOLD:       cfg_r.dry_threshold       <= cfg_data[HUM_W-1:0];
        REG_WET_THRESHOLD:       cfg_r.wet_threshold       <= cfg_data[HUM_W-1:0];
        REG_RESERVOIR_THRESHOLD: cfg_r.reservoir_threshold <= cfg_data[HUM_W-1:0];
        REG_PUMP_TIME_SECONDS:   cfg_r.pump_time_seconds   <= cfg_data[SEC_W-1:0];
        REG_SOAK_MINUTES:        cfg_r.soak_limit_ms       <= soak_limit_nxt[TIME_W-1:0];
        REG_MAX_PASSES:          cfg_r.max_passes          <= cfg_data[PASS_W-1:0];
        REG_RECHECK_INTERVAL_MS: cfg_r.recheck_interval_ms <= cfg_data[TIME_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // state machine and result register
  wcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_req_r),
    .cfg   (cfg_r),
    .res_r (out_data)
  );

  // a pump start is only reported on entry to the pump mode
  `WCS_ASSERT_NOW(a_pump_start_mode,
    out_valid_r && (out_data.pump_valve_action == PUMP_START),
    out_data.mode == MODE_PUMP)
  // an empty reservoir always parks the cycle in the empty mode
  `WCS_ASSERT_NOW(a_tank_empty_mode,
    out_valid_r && (out_data.event_res == EVT_TANK_EMPTY),
    out_data.mode == MODE_TANK_EMPTY)
  // the cycle ends when the soil is already wet
  `WCS_ASSERT_NOW(a_soil_wet_idle,
    out_valid_r && (out_data.event_res == EVT_SOIL_NOT_DRY),
    out_data.mode == MODE_IDLE)
  // back pressure only when both registers are full and the sink stalls
  `WCS_ASSERT_NOW(a_ready_only_when_full,
    !in_ready,
    s1_valid_r && out_valid_r && !out_ready)
  // a request leaving the input register always lands in the result register
  `WCS_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_r)

endmodule
